### design/olist_pkg.sv
// Shared types, codes and sizing for the ordered list block.
package olist_pkg;

    // List sizing
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [1:0]        mode_t;
    typedef logic [2:0]        status_t;

    // Item modes
    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_DELETE = 2'd1;
    localparam mode_t MODE_DUMP   = 2'd2;

    // Result status codes
    localparam status_t STS_INSERTED  = 3'd0;
    localparam status_t STS_REMOVED   = 3'd1;
    localparam status_t STS_NOT_FOUND = 3'd2;
    localparam status_t STS_FULL      = 3'd3;
    localparam status_t STS_EMPTY     = 3'd4;
    localparam status_t STS_ENTRY     = 3'd5;

    // Memory access request from the sequencer
    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        data_t wr_data;
        logic  rd_en;
        addr_t rd_addr;
    } mem_req_t;

    // One result item
    typedef struct packed {
        status_t status;
        data_t   entry_value;
        logic    last;
    } res_t;

endpackage

### design/olist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module olist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/olist_seq.sv
// Sequencer: insert, delete search and compaction, and dump over the entry memory.
module olist_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  olist_pkg::mode_t     s_mode,
    input  olist_pkg::data_t     s_value,
    output olist_pkg::mem_req_t  mem_req,
    input  olist_pkg::data_t     mem_rd_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output olist_pkg::res_t      res
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_DUMP   = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    olist_pkg::cnt_t       cnt_reg, cnt_next;
    olist_pkg::addr_t      ptr_reg, ptr_next;     // index of the data arriving from memory
    olist_pkg::data_t      key_reg, key_next;
    olist_pkg::status_t    resp_reg, resp_next;

    olist_pkg::cnt_t       ptr_ext;
    logic                  match;

    assign ptr_ext = olist_pkg::cnt_t'(ptr_reg);
    assign match   = (mem_rd_data == key_reg);
    assign s_ready = (state_reg == ST_IDLE);

    // Next-state and memory access logic
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        key_next   = key_reg;
        resp_next  = resp_reg;
        mem_req    = '0;
        res_valid  = 1'b0;
        res        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        olist_pkg::MODE_INSERT: begin
                            if (cnt_reg == olist_pkg::cnt_t'(olist_pkg::CAPACITY)) begin
                                resp_next = olist_pkg::STS_FULL;
                            end else begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = olist_pkg::addr_t'(cnt_reg);
                                mem_req.wr_data = s_value;
                                cnt_next        = cnt_reg + 1'b1;
                                resp_next       = olist_pkg::STS_INSERTED;
                            end
                            state_next = ST_RESP;
                        end
                        olist_pkg::MODE_DELETE: begin
                            key_next = s_value;
                            if (cnt_reg == '0) begin
                                resp_next  = olist_pkg::STS_NOT_FOUND;
                                state_next = ST_RESP;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = olist_pkg::addr_t'(cnt_reg - 1'b1);
                                ptr_next        = olist_pkg::addr_t'(cnt_reg - 1'b1);
                                state_next      = ST_SEARCH;
                            end
                        end
                        olist_pkg::MODE_DUMP: begin
                            if (cnt_reg == '0) begin
                                resp_next  = olist_pkg::STS_EMPTY;
                                state_next = ST_RESP;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = olist_pkg::addr_t'(cnt_reg - 1'b1);
                                ptr_next        = olist_pkg::addr_t'(cnt_reg - 1'b1);
                                state_next      = ST_DUMP;
                            end
                        end
                        default: begin
                            // unused mode: item dropped without a result
                        end
                    endcase
                end
            end

            // Walk from head toward tail until the key matches or the tail is passed
            ST_SEARCH: begin
                if (match) begin
                    if (ptr_ext + 1'b1 < cnt_reg) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ptr_reg + 1'b1;
                        state_next      = ST_SHIFT;
                    end else begin
                        // match at the head: nothing to move
                        cnt_next   = cnt_reg - 1'b1;
                        resp_next  = olist_pkg::STS_REMOVED;
                        state_next = ST_RESP;
                    end
                end else if (ptr_reg == '0) begin
                    resp_next  = olist_pkg::STS_NOT_FOUND;
                    state_next = ST_RESP;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg - 1'b1;
                    ptr_next        = ptr_reg - 1'b1;
                end
            end

            // Move entries above the hole down by one; reads run one slot ahead of writes
            ST_SHIFT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ptr_reg;
                mem_req.wr_data = mem_rd_data;
                if (ptr_ext + 2'd2 < cnt_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg + 2'd2;
                    ptr_next        = ptr_reg + 1'b1;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    resp_next  = olist_pkg::STS_REMOVED;
                    state_next = ST_RESP;
                end
            end

            // Emit entries head to tail; read data holds while the output stalls
            ST_DUMP: begin
                res_valid         = 1'b1;
                res.status        = olist_pkg::STS_ENTRY;
                res.entry_value   = mem_rd_data;
                res.last          = (ptr_reg == '0);
                if (res_ready) begin
                    if (ptr_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ptr_reg - 1'b1;
                        ptr_next        = ptr_reg - 1'b1;
                    end
                end
            end

            // Single status result
            ST_RESP: begin
                res_valid  = 1'b1;
                res.status = resp_reg;
                res.last   = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        ptr_reg  <= ptr_next;
        key_reg  <= key_next;
        resp_reg <= resp_next;
    end

    // Count stays within capacity
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= olist_pkg::cnt_t'(olist_pkg::CAPACITY))
        else $error("entry count above capacity");

    // Compaction never reads the slot it writes in the same cycle
    a_shift_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
        else $error("read and write hit the same slot");

    // The count changes only on the way to a status result
    a_cnt_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (cnt_reg != $past(cnt_reg))) |-> (state_reg == ST_RESP))
        else $error("entry count changed outside insert or delete");

endmodule

### design/olist_obuf.sv
// Output register with a skid stage for the result channel.
module olist_obuf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    output logic             res_ready,
    input  olist_pkg::res_t  res,
    output logic             m_valid,
    input  logic             m_ready,
    output olist_pkg::res_t  m_res
);

    logic            out_valid_reg;
    logic            skid_valid_reg;
    olist_pkg::res_t main_reg;
    olist_pkg::res_t skid_reg;
    logic            in_fire;

    assign res_ready = !skid_valid_reg;
    assign in_fire   = res_valid && res_ready;
    assign m_valid   = out_valid_reg;
    assign m_res     = main_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            main_reg <= skid_valid_reg ? skid_reg : res;
        end else if (in_fire) begin
            skid_reg <= res;
        end
    end

    // A held skid item always has an item ahead of it
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid item without an output item");

endmodule

### design/ordered_list_insert_front_delete.sv
// Insert, full drop, empty delete or dump give one status result; an unused mode gives no result.
// Delete: searches up to CAPACITY entries from the head, then moves up to CAPACITY-1 entries down.
// Dump: one entry per cycle through the single memory read port while the output accepts.
// One item at a time; the next item is taken once the current one has handed off its last result.
// Reset (aresetn low, synchronous) clears the entry count and the handshakes; memory is not cleared.
module ordered_list_insert_front_delete (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic signed [31:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic signed [31:0]  m_entry_value,
    output logic                m_last
);

    olist_pkg::mem_req_t mem_req;
    olist_pkg::data_t    mem_rd_data;
    olist_pkg::res_t     seq_res;
    olist_pkg::res_t     out_res;
    logic                seq_res_valid;
    logic                seq_res_ready;

    // Entry memory
    olist_ram #(
        .WIDTH (olist_pkg::DATA_W),
        .DEPTH (olist_pkg::CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    // Item sequencer
    olist_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_value     (olist_pkg::data_t'(s_value)),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_valid   (seq_res_valid),
        .res_ready   (seq_res_ready),
        .res         (seq_res)
    );

    // Result output stage
    olist_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (seq_res_valid),
        .res_ready (seq_res_ready),
        .res       (seq_res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (out_res)
    );

    assign m_status      = out_res.status;
    assign m_entry_value = $signed(out_res.entry_value);
    assign m_last        = out_res.last;

endmodule

### tb/testbench.sv
// Self-checking testbench for the ordered list block: directed table then random list traffic.
`timescale 1ns / 1ps

module testbench;
    import olist_pkg::*;

    // Test sizing and watchdog limit
    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    DRAIN_CYCLES = 50;
    localparam int    RAND_ITEMS   = 382;
    localparam int    HOLD_AFTER   = 120;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    PAUSE_AT     = 200;
    localparam int    NUM_ROWS     = 18;
    localparam mode_t MODE_UNUSED  = 2'd3;

    // One row of directed stimulus; typed rows carry their single expected status
    typedef struct packed {
        mode_t   mode;
        data_t   value;
        int      reps;
        int      step;
        logic    typed;
        status_t exp_status;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_mode;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic signed [31:0] m_entry_value;
    logic               m_last;

    // Shadow copy of the list: slot len-1 is the head, slot 0 the tail
    data_t     model_entries [CAPACITY];
    int        model_len;
    res_t      op_results [$];
    res_t      list_results_q [$];
    stim_row_t dir_rows [NUM_ROWS];

    int cycle_cnt;
    int mismatch_cnt;
    int results_seen;
    bit burst;
    bit hold_done;

    ordered_list_insert_front_delete i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_value (m_entry_value),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one list operation to the shadow list, collect its responses in op_results
    function automatic void apply_list_op(input mode_t mode, input data_t value);
        res_t r;
        int   hit;
        op_results.delete();
        r.entry_value = '0;
        r.last        = 1'b1;
        case (mode)
            MODE_INSERT: begin
                if (model_len >= CAPACITY) begin
                    r.status = STS_FULL;
                end else begin
                    model_entries[model_len] = value;
                    model_len++;
                    r.status = STS_INSERTED;
                end
                op_results.push_back(r);
            end
            MODE_DELETE: begin
                hit = -1;
                for (int i = model_len - 1; i >= 0 && hit < 0; i--)
                    if (model_entries[i] == value) hit = i;
                if (hit < 0) begin
                    r.status = STS_NOT_FOUND;
                end else begin
                    for (int j = hit; j + 1 < model_len; j++)
                        model_entries[j] = model_entries[j + 1];
                    model_len--;
                    r.status = STS_REMOVED;
                end
                op_results.push_back(r);
            end
            MODE_DUMP: begin
                if (model_len == 0) begin
                    r.status = STS_EMPTY;
                    op_results.push_back(r);
                end else begin
                    for (int i = model_len - 1; i >= 0; i--) begin
                        r.status      = STS_ENTRY;
                        r.entry_value = model_entries[i];
                        r.last        = (i == 0);
                        op_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Mostly a small pool so deletes hit and duplicates occur, some extremes, some full range
    function automatic data_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return data_t'($signed($urandom_range(0, 15)) - 8);
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Offer one item after a random gap; on acceptance queue up its expected responses
    task automatic send_item(input mode_t mode, input data_t value,
                             input logic typed, input status_t exp_status);
        int   gap;
        res_t r;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_list_op(mode, value);
        if (typed) begin
            r.status      = exp_status;
            r.entry_value = '0;
            r.last        = 1'b1;
            list_results_q.push_back(r);
        end else begin
            while (op_results.size() > 0) list_results_q.push_back(op_results.pop_front());
        end
        @(negedge aclk);
    endtask

    // Directed table
    initial begin
        dir_rows[0]  = '{MODE_DUMP,   32'h0000_0000, 1, 0, 1'b1, STS_EMPTY};
        dir_rows[1]  = '{MODE_DELETE, 32'h0000_0000, 1, 0, 1'b1, STS_NOT_FOUND};
        dir_rows[2]  = '{MODE_UNUSED, 32'hFFFF_FFFF, 1, 0, 1'b0, STS_INSERTED};
        dir_rows[3]  = '{MODE_INSERT, 32'h7FFF_FFFF, 1, 0, 1'b1, STS_INSERTED};
        dir_rows[4]  = '{MODE_INSERT, 32'h8000_0000, 1, 0, 1'b1, STS_INSERTED};
        dir_rows[5]  = '{MODE_INSERT, 32'hFFFF_FFFF, 1, 0, 1'b1, STS_INSERTED};
        dir_rows[6]  = '{MODE_INSERT, 32'h0000_0000, 1, 0, 1'b1, STS_INSERTED};
        dir_rows[7]  = '{MODE_INSERT, 32'h0000_0007, 1, 0, 1'b1, STS_INSERTED};
        dir_rows[8]  = '{MODE_DUMP,   32'h1234_5678, 1, 0, 1'b0, STS_INSERTED};
        dir_rows[9]  = '{MODE_DELETE, 32'h8000_0000, 1, 0, 1'b1, STS_REMOVED};
        dir_rows[10] = '{MODE_DELETE, 32'h1234_5678, 1, 0, 1'b1, STS_NOT_FOUND};
        dir_rows[11] = '{MODE_DELETE, 32'h7FFF_FFFF, 1, 0, 1'b1, STS_REMOVED};
        // three left, fill up to capacity
        dir_rows[12] = '{MODE_INSERT, 32'hA5A5_0000, 13, 1, 1'b1, STS_INSERTED};
        dir_rows[13] = '{MODE_INSERT, 32'h5A5A_5A5A, 1, 0, 1'b1, STS_FULL};
        dir_rows[14] = '{MODE_DUMP,   32'h0000_0000, 1, 0, 1'b0, STS_INSERTED};
        dir_rows[15] = '{MODE_DELETE, 32'hA5A5_000C, 1, 0, 1'b1, STS_REMOVED};
        dir_rows[16] = '{MODE_DELETE, 32'hFFFF_FFFF, 1, 0, 1'b1, STS_REMOVED};
        dir_rows[17] = '{MODE_DUMP,   32'hFFFF_FFFF, 1, 0, 1'b0, STS_INSERTED};
    end

    // Reset, directed part, random part, drain and verdict
    initial begin
        int    rand_items;
        int    r;
        bit    grow;
        bit    pause_done;
        mode_t md;
        data_t val;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_mode     = MODE_INSERT;
        s_value    = '0;
        model_len  = 0;
        burst      = 1'b0;
        pause_done = 1'b0;
        rand_items = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NUM_ROWS; i++)
            for (int k = 0; k < dir_rows[i].reps; k++)
                send_item(dir_rows[i].mode, dir_rows[i].value + data_t'(k * dir_rows[i].step),
                          dir_rows[i].typed, dir_rows[i].exp_status);

        // Alternate growing and shrinking phases so the list swings between empty and full
        while (rand_items < RAND_ITEMS) begin
            grow  = ((rand_items / 40) % 2) == 0;
            burst = (rand_items >= 100 && rand_items < 160);
            if (rand_items == PAUSE_AT && !pause_done) begin
                pause_done = 1'b1;
                s_valid <= 1'b0;
                while (list_results_q.size() > 0) @(posedge aclk);
                @(negedge aclk);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                md = MODE_UNUSED;
            else if (r < 15)
                md = MODE_DUMP;
            else if (r < (grow ? 70 : 40))
                md = MODE_INSERT;
            else
                md = MODE_DELETE;
            if (md == MODE_DELETE && model_len > 0 && $urandom_range(0, 9) < 7)
                val = model_entries[$urandom_range(0, model_len - 1)];
            else
                val = pick_value();
            send_item(md, val, 1'b0, STS_INSERTED);
            if (md != MODE_UNUSED) rand_items++;
        end
        s_valid <= 1'b0;

        while (list_results_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && list_results_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls per item, one long hold-off to back up the input
    initial begin
        int gap;
        m_ready   = 1'b0;
        hold_done = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = burst ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Compare each accepted item with the oldest expected response
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (list_results_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected item: status %0d value %h last %0d",
                             m_status, m_entry_value, m_last);
            end else begin
                want = list_results_q.pop_front();
                if (m_status !== want.status || m_entry_value !== want.entry_value ||
                    m_last !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected status %0d value %h last %0d, got %0d %h %0d",
                                 want.status, want.entry_value, want.last,
                                 m_status, m_entry_value, m_last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

### filelist.f
design/olist_pkg.sv
design/olist_ram.sv
design/olist_seq.sv
design/olist_obuf.sv
design/ordered_list_insert_front_delete.sv
tb/testbench.sv
